// ===== hdl/ttb_pkg.sv =====
// Shared types, widths and constants of the triangle tangent and bitangent unit.
package ttb_pkg;

  localparam int PosW     = 32;
  localparam int TexW     = 16;
  localparam int DPosW    = PosW + 1;
  localparam int DTexW    = TexW + 1;
  localparam int ProdW    = DPosW + DTexW;
  localparam int NumW     = ProdW + 1;
  localparam int DetW     = 35;
  localparam int ShiftW   = 12;
  localparam int RemW     = NumW + ShiftW;
  localparam int QuoW     = 33;
  localparam int DsW      = DetW + QuoW - 1;
  localparam int CmpW     = DetW + QuoW;
  localparam int NumComp  = 4;
  localparam int NumVec   = 2 * NumComp;
  localparam int SelW     = 4;
  localparam int StepW    = 6;
  localparam int DivSteps = QuoW;

  localparam logic [SelW-1:0] SelDet = SelW'(0);
  localparam logic [PosW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [PosW-1:0] SatMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [PosW-1:0] pos_w;
    logic signed [TexW-1:0] tex_u;
    logic signed [TexW-1:0] tex_v;
  } corner_t;

  typedef struct packed {
    logic signed [PosW-1:0] tangent_x;
    logic signed [PosW-1:0] tangent_y;
    logic signed [PosW-1:0] tangent_z;
    logic signed [PosW-1:0] tangent_w;
    logic signed [PosW-1:0] bitangent_x;
    logic signed [PosW-1:0] bitangent_y;
    logic signed [PosW-1:0] bitangent_z;
    logic signed [PosW-1:0] bitangent_w;
    logic                   degenerate;
  } result_t;

  typedef struct packed {
    logic            hold_en;
    logic            hold_slot;
    logic            delta_en;
    logic            mul_en;
    logic [SelW-1:0] mul_sel;
    logic            div_start;
    logic            div_step;
    logic            out_load;
  } ttb_cmd_t;

  typedef struct packed {
    logic det_zero;
  } ttb_sts_t;

endpackage

// ===== hdl/ttb_if.sv =====
// Request channel interfaces for triangle corners and tangent results.
interface ttb_corner_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  pos_z;
  logic signed [31:0]  pos_w;
  logic signed [15:0]  tex_u;
  logic signed [15:0]  tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, pos_w, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, pos_w, tex_u, tex_v, output ready);
endinterface

interface ttb_result_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  tangent_x;
  logic signed [31:0]  tangent_y;
  logic signed [31:0]  tangent_z;
  logic signed [31:0]  tangent_w;
  logic signed [31:0]  bitangent_x;
  logic signed [31:0]  bitangent_y;
  logic signed [31:0]  bitangent_z;
  logic signed [31:0]  bitangent_w;
  logic                degenerate;

  modport source (
    output valid, tangent_x, tangent_y, tangent_z, tangent_w,
    bitangent_x, bitangent_y, bitangent_z, bitangent_w, degenerate,
    input ready
  );
  modport sink (
    input valid, tangent_x, tangent_y, tangent_z, tangent_w,
    bitangent_x, bitangent_y, bitangent_z, bitangent_w, degenerate,
    output ready
  );
endinterface

// ===== hdl/ttb_dp.sv =====
// Datapath: held corners, deltas, shared multiplier pair, eight divider lanes, result register.
module ttb_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttb_pkg::corner_t  corner_i,
  input  ttb_pkg::ttb_cmd_t cmd_i,
  output ttb_pkg::ttb_sts_t sts_o,
  output ttb_pkg::result_t  result_o
);
  import ttb_pkg::*;

  logic signed [PosW-1:0]  pos_in [NumComp];
  logic signed [PosW-1:0]  hold_pos_q [2][NumComp];
  logic signed [TexW-1:0]  hold_u_q [2];
  logic signed [TexW-1:0]  hold_v_q [2];

  logic signed [DPosW-1:0] e1_q [NumComp];
  logic signed [DPosW-1:0] e2_q [NumComp];
  logic signed [DTexW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  logic signed [DPosW-1:0] ax, bx;
  logic signed [DTexW-1:0] ay, by;
  logic [SelW-1:0]         vec_idx;
  logic [1:0]              comp;
  logic                    is_bitan;

  logic signed [ProdW-1:0] prod_a_q, prod_b_q;
  logic                    prod_vld_q;
  logic [SelW-1:0]         prod_sel_q;
  logic signed [NumW-1:0]  diff;

  logic signed [DetW-1:0]  det_q;
  logic signed [NumW-1:0]  num_q [NumVec];
  logic [DetW-1:0]         det_mag;

  logic [RemW-1:0]         rem_q [NumVec];
  logic [QuoW-1:0]         quo_q [NumVec];
  logic                    ovf_q [NumVec];
  logic                    neg_q [NumVec];
  logic [DsW-1:0]          ds_q;

  logic [PosW-1:0]         lane_out [NumVec];
  result_t                 res_q;

  function automatic logic [PosW-1:0] sat_lane(input logic neg, input logic ovf,
                                               input logic [QuoW-1:0] q);
    logic [PosW-1:0] r;
    if (!neg) begin
      r = (ovf || q[QuoW-1] || q[QuoW-2]) ? SatMax : q[PosW-1:0];
    end else begin
      r = (ovf || (q > QuoW'(SatMin))) ? SatMin : (~q[PosW-1:0] + PosW'(1));
    end
    return r;
  endfunction

  assign pos_in[0] = corner_i.pos_x;
  assign pos_in[1] = corner_i.pos_y;
  assign pos_in[2] = corner_i.pos_z;
  assign pos_in[3] = corner_i.pos_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_en) begin
      for (int i = 0; i < NumComp; i++) begin
        hold_pos_q[cmd_i.hold_slot][i] <= pos_in[i];
      end
      hold_u_q[cmd_i.hold_slot] <= corner_i.tex_u;
      hold_v_q[cmd_i.hold_slot] <= corner_i.tex_v;
    end
    if (cmd_i.delta_en) begin
      for (int i = 0; i < NumComp; i++) begin
        e1_q[i] <= DPosW'(hold_pos_q[1][i]) - DPosW'(hold_pos_q[0][i]);
        e2_q[i] <= DPosW'(pos_in[i]) - DPosW'(hold_pos_q[0][i]);
      end
      du1_q <= DTexW'(hold_u_q[1]) - DTexW'(hold_u_q[0]);
      dv1_q <= DTexW'(hold_v_q[1]) - DTexW'(hold_v_q[0]);
      du2_q <= DTexW'(corner_i.tex_u) - DTexW'(hold_u_q[0]);
      dv2_q <= DTexW'(corner_i.tex_v) - DTexW'(hold_v_q[0]);
    end
  end

  assign vec_idx  = cmd_i.mul_sel - SelW'(1);
  assign comp     = vec_idx[1:0];
  assign is_bitan = vec_idx[2];

  always_comb begin
    if (cmd_i.mul_sel == SelDet) begin
      ax = DPosW'(du1_q);
      ay = dv2_q;
      bx = DPosW'(dv1_q);
      by = du2_q;
    end else if (is_bitan) begin
      ax = e2_q[comp];
      ay = du1_q;
      bx = e1_q[comp];
      by = du2_q;
    end else begin
      ax = e1_q[comp];
      ay = dv2_q;
      bx = e2_q[comp];
      by = dv1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_a_q   <= ax * ay;
      prod_b_q   <= bx * by;
      prod_sel_q <= cmd_i.mul_sel;
    end
  end

  assign diff = NumW'(prod_a_q) - NumW'(prod_b_q);

  always_ff @(posedge clk_i) begin
    if (prod_vld_q && (prod_sel_q == SelDet)) begin
      det_q <= diff[DetW-1:0];
    end
    for (int j = 0; j < NumVec; j++) begin
      if (prod_vld_q && (prod_sel_q == SelW'(j + 1))) begin
        num_q[j] <= diff;
      end
    end
  end

  assign sts_o.det_zero = (det_q == '0);
  assign det_mag = det_q[DetW-1] ? (~det_q + DetW'(1)) : det_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      ds_q <= {det_mag, {(QuoW-1){1'b0}}};
    end else if (cmd_i.div_step) begin
      ds_q <= ds_q >> 1;
    end
  end

  for (genvar j = 0; j < NumVec; j++) begin : g_lane
    logic [NumW-1:0] num_mag;
    logic [RemW-1:0] dividend;
    logic            ge;

    assign num_mag  = num_q[j][NumW-1] ? (~num_q[j] + NumW'(1)) : num_q[j];
    assign dividend = {num_mag, {ShiftW{1'b0}}};
    assign ge       = (CmpW'(rem_q[j]) >= CmpW'(ds_q));

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_start) begin
        rem_q[j] <= dividend;
        quo_q[j] <= '0;
        ovf_q[j] <= (CmpW'(dividend) >= {det_mag, {QuoW{1'b0}}});
        neg_q[j] <= num_q[j][NumW-1] ^ det_q[DetW-1];
      end else if (cmd_i.div_step) begin
        if (ge) begin
          rem_q[j] <= rem_q[j] - ds_q[RemW-1:0];
        end
        quo_q[j] <= {quo_q[j][QuoW-2:0], ge};
      end
    end

    assign lane_out[j] = sts_o.det_zero ? '0 : sat_lane(neg_q[j], ovf_q[j], quo_q[j]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.tangent_x   <= lane_out[0];
      res_q.tangent_y   <= lane_out[1];
      res_q.tangent_z   <= lane_out[2];
      res_q.tangent_w   <= lane_out[3];
      res_q.bitangent_x <= lane_out[4];
      res_q.bitangent_y <= lane_out[5];
      res_q.bitangent_z <= lane_out[6];
      res_q.bitangent_w <= lane_out[7];
      res_q.degenerate  <= sts_o.det_zero;
    end
  end

  assign result_o = res_q;

endmodule

// ===== hdl/ttb_ctrl.sv =====
// Controller: corner counting and sequencing of the multiply, divide and output steps.
module ttb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ttb_pkg::ttb_cmd_t cmd_o,
  input  ttb_pkg::ttb_sts_t sts_i
);
  import ttb_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StDivSt = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [1:0]       count_q, count_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (count_q == 2'd2) begin
            cmd_o.delta_en = 1'b1;
            count_d        = 2'd0;
            step_d         = '0;
            state_d        = StMul;
          end else begin
            cmd_o.hold_en   = 1'b1;
            cmd_o.hold_slot = (count_q == 2'd1);
            count_d         = (count_q == 2'd1) ? 2'd2 : 2'd1;
          end
        end
      end
      StMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = step_q[SelW-1:0];
        if (step_q == StepW'(NumVec)) begin
          state_d = StDrain;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StDrain: begin
        state_d = StDivSt;
      end
      StDivSt: begin
        if (sts_i.det_zero) begin
          state_d = StDone;
        end else begin
          cmd_o.div_start = 1'b1;
          step_d          = '0;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = StDone;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= 2'd0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("corner count reached an unused value");

  a_third_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && count_q == 2'd2) |=> (state_q == StMul && count_q == 2'd0))
    else $error("third corner did not start the multiply sequence");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result request raised outside the done step");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_valid_q && !out_ready_i) |=> (state_q == StDone))
    else $error("finished result overwrote a pending request");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (step_q < StepW'(DivSteps)))
    else $error("divider step count out of range");

endmodule

// ===== hdl/triangle_tangent_bitangent.sv =====
// Top level of the triangle tangent and bitangent unit.
//
//   Channel    Modport   Direction  Request content
//   corner_i   sink      in         one triangle corner: position xyzw, texcoord uv
//   result_o   source    out        tangent xyzw, bitangent xyzw, degenerate flag
//
// The first two corners of a triangle are held in registers.
// The third corner forms the deltas and is followed by nine slots
// on the shared multiplier pair, then 33 steps of the bit-per-cycle divider lanes;
// the divider steps are skipped when the UV determinant is zero.
// Reset is asynchronous and active low and clears the corner count and control state.
// A finished result waits in the output register; the next triangle's corners are
// accepted meanwhile, and its result stalls only if the previous one is still pending.
module triangle_tangent_bitangent (
  input  logic          clk_i,
  input  logic          rst_ni,
  ttb_corner_if.sink    corner_i,
  ttb_result_if.source  result_o
);
  import ttb_pkg::*;

  corner_t  corner;
  result_t  result;
  ttb_cmd_t cmd;
  ttb_sts_t sts;

  assign corner.pos_x = corner_i.pos_x;
  assign corner.pos_y = corner_i.pos_y;
  assign corner.pos_z = corner_i.pos_z;
  assign corner.pos_w = corner_i.pos_w;
  assign corner.tex_u = corner_i.tex_u;
  assign corner.tex_v = corner_i.tex_v;

  ttb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corner_i.valid),
    .in_ready_o  (corner_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ttb_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .corner_i (corner),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result)
  );

  assign result_o.tangent_x   = result.tangent_x;
  assign result_o.tangent_y   = result.tangent_y;
  assign result_o.tangent_z   = result.tangent_z;
  assign result_o.tangent_w   = result.tangent_w;
  assign result_o.bitangent_x = result.bitangent_x;
  assign result_o.bitangent_y = result.bitangent_y;
  assign result_o.bitangent_z = result.bitangent_z;
  assign result_o.bitangent_w = result.bitangent_w;
  assign result_o.degenerate  = result.degenerate;

endmodule
